// ----- hdl/msf_pkg.sv -----
// Shared constants for the minimum-energy seam finder.
`timescale 1ns / 1ps
package msf_pkg;

    // Fixed field widths
    localparam int GRAD_W     = 8;
    localparam int ENERGY_W   = 14;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_W_W    = 9;
    localparam int CFG_H_W    = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Stand-in for a neighbor that lies outside the image
    localparam logic [ENERGY_W-1:0] ENERGY_NONE = {ENERGY_W{1'b1}};

endpackage

// ----- hdl/min_energy_seam_finder_core.sv -----
// Top level of the minimum-energy vertical seam finder.
`timescale 1ns / 1ps
// Loads a width x height gradient frame, one pixel per cycle while o_ready is
// high. The transaction that completes the frame starts the search and o_ready
// stays low until the bottom row's seam entry has been handed to the output
// register: the energy pass works through every pixel from the bottom row up,
// the top-row minimum search then scans each column, and the trace reads three
// neighbors per row and hands out one result per row (waiting while the output is
// stalled). Everything is paced by the single read port of the energy memory.
// Seam entries come out top row first with o_last on the bottom row.
// Configuration writes are always taken; width and height writes discard a partial frame.
module min_energy_seam_finder_core
    import msf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [GRAD_W-1:0]     i_gradient,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ROW_W-1:0]      o_row,
    output logic [COL_W-1:0]      o_seam_column,
    output logic                  o_last
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Sequencer states
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_EPRIME = 4'd1;
    localparam logic [3:0] S_EPRIM2 = 4'd2;
    localparam logic [3:0] S_ERD    = 4'd3;
    localparam logic [3:0] S_EWR    = 4'd4;
    localparam logic [3:0] S_MRD    = 4'd5;
    localparam logic [3:0] S_MCMP   = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;
    localparam logic [3:0] S_TL     = 4'd8;
    localparam logic [3:0] S_TM     = 4'd9;
    localparam logic [3:0] S_TR     = 4'd10;
    localparam logic [3:0] S_TD     = 4'd11;

    logic [CFG_W_W-1:0]  r_cfg_w;
    logic [CFG_H_W-1:0]  r_cfg_h;
    logic [3:0]          r_state;
    logic [AW-1:0]       r_cnt;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       r_pos;
    logic [AW-1:0]       r_cur;
    logic [ENERGY_W-1:0] r_el;
    logic [ENERGY_W-1:0] r_em;
    logic [ENERGY_W-1:0] r_best;
    logic                r_out_valid;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic                r_out_last;

    logic [GRAD_W-1:0]   mem_grad [DEPTH];
    logic [ENERGY_W-1:0] mem_energy [DEPTH];
    logic [GRAD_W-1:0]   r_grad_rd;
    logic [ENERGY_W-1:0] r_energy_rd;

    logic [WW-1:0]       w_eff;
    logic [HW-1:0]       h_eff;
    logic [TW-1:0]       total;
    logic [AW-1:0]       below;
    logic                col_last;
    logic                row_bottom;
    logic                pos_first;
    logic                pos_last;
    logic                out_free;
    logic [AW-1:0]       grad_raddr;
    logic [AW-1:0]       energy_raddr;
    logic                grad_we;
    logic                energy_we;
    logic [AW-1:0]       energy_waddr;
    logic [ENERGY_W-1:0] energy_wdata;
    logic [ENERGY_W-1:0] e_right;
    logic [ENERGY_W-1:0] e_best;
    logic [ENERGY_W-1:0] t_right;
    logic [ENERGY_W-1:0] t_min;

    // Clamp the configured size into the supported range
    always_comb begin
        if (r_cfg_w < CFG_W_W'(2)) begin
            w_eff = WW'(2);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
    end

    assign total      = TW'(32'(w_eff) * 32'(h_eff));
    assign below      = r_cur + AW'(w_eff);
    assign col_last   = (32'(r_col) + 1 == 32'(w_eff));
    assign row_bottom = (32'(r_row) + 1 == 32'(h_eff));
    assign pos_first  = (r_pos == '0);
    assign pos_last   = (32'(r_pos) + 1 == 32'(w_eff));
    assign out_free   = !r_out_valid || i_ready;

    assign o_cfg_ready   = 1'b1;
    assign o_ready       = (r_state == S_LOAD);
    assign o_valid       = r_out_valid;
    assign o_row         = r_out_row;
    assign o_seam_column = r_out_col;
    assign o_last        = r_out_last;

    // Energy pass datapath: min of the three entries below plus the gradient
    assign e_right = col_last ? ENERGY_NONE : r_energy_rd;
    always_comb begin
        e_best = r_em;
        if (r_el < e_best) begin
            e_best = r_el;
        end
        if (e_right < e_best) begin
            e_best = e_right;
        end
        if (row_bottom) begin
            e_best = '0;
        end
    end
    assign energy_wdata = ENERGY_W'(r_grad_rd) + e_best;

    // Trace datapath
    assign t_right = pos_last ? ENERGY_NONE : r_energy_rd;
    assign t_min   = (r_el < r_em) ? r_el : r_em;

    // Memory port control
    always_comb begin
        grad_raddr   = r_cur + AW'(r_col);
        energy_raddr = below;
        grad_we      = (r_state == S_LOAD) && i_valid;
        energy_we    = (r_state == S_EWR);
        energy_waddr = r_cur + AW'(r_col);
        case (r_state)
            S_ERD:   energy_raddr = below + AW'(r_col) + AW'(1);
            S_MRD:   energy_raddr = AW'(r_col);
            S_TL:    energy_raddr = r_cur + AW'(r_pos) - AW'(1);
            S_TM:    energy_raddr = r_cur + AW'(r_pos);
            S_TR:    energy_raddr = r_cur + AW'(r_pos) + AW'(1);
            default: energy_raddr = below;
        endcase
    end

    // Frame stores
    always_ff @(posedge i_clk) begin
        if (grad_we) begin
            mem_grad[r_cnt] <= i_gradient;
        end
        r_grad_rd <= mem_grad[grad_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (energy_we) begin
            mem_energy[energy_waddr] <= energy_wdata;
        end
        r_energy_rd <= mem_energy[energy_raddr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W_W'(256);
            r_cfg_h <= CFG_H_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                default:          r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register: load a new entry or drop the accepted one
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid && (i_cfg_index == REG_IMAGE_WIDTH ||
                                        i_cfg_index == REG_IMAGE_HEIGHT)) begin
                        r_cnt <= '0;
                    end else if (i_valid) begin
                        if (TW'(r_cnt) + TW'(1) == total) begin
                            r_cnt   <= '0;
                            r_row   <= RW'(h_eff - HW'(1));
                            r_cur   <= AW'(total - TW'(w_eff));
                            r_col   <= '0;
                            r_state <= S_EPRIME;
                        end else begin
                            r_cnt <= r_cnt + AW'(1);
                        end
                    end
                end
                S_EPRIME: begin
                    r_state <= row_bottom ? S_ERD : S_EPRIM2;
                end
                S_EPRIM2: begin
                    r_el    <= ENERGY_NONE;
                    r_em    <= r_energy_rd;
                    r_state <= S_ERD;
                end
                S_ERD: begin
                    r_state <= S_EWR;
                end
                S_EWR: begin
                    r_el <= r_em;
                    r_em <= e_right;
                    if (col_last) begin
                        r_col <= '0;
                        if (r_row == '0) begin
                            r_state <= S_MRD;
                        end else begin
                            r_row   <= r_row - RW'(1);
                            r_cur   <= r_cur - AW'(w_eff);
                            r_state <= S_EPRIME;
                        end
                    end else begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_ERD;
                    end
                end
                S_MRD: begin
                    r_state <= S_MCMP;
                end
                S_MCMP: begin
                    if (r_col == '0 || r_energy_rd < r_best) begin
                        r_best <= r_energy_rd;
                        r_pos  <= r_col;
                    end
                    if (col_last) begin
                        r_row   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_MRD;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_row   <= ROW_W'(r_row);
                        r_out_col   <= COL_W'(r_pos);
                        r_out_last  <= row_bottom;
                        if (row_bottom) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_row   <= r_row + RW'(1);
                            r_cur   <= r_cur + AW'(w_eff);
                            r_state <= S_TL;
                        end
                    end
                end
                S_TL: begin
                    r_state <= S_TM;
                end
                S_TM: begin
                    r_el    <= pos_first ? ENERGY_NONE : r_energy_rd;
                    r_state <= S_TR;
                end
                S_TR: begin
                    r_em    <= r_energy_rd;
                    r_state <= S_TD;
                end
                S_TD: begin
                    // Right wins only on a strict improvement over both
                    if (t_right < t_min) begin
                        r_pos <= r_pos + CW'(1);
                    end else if (r_el < r_em) begin
                        r_pos <= r_pos - CW'(1);
                    end
                    r_state <= S_OUT;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// ----- hdl/msf_checker.sv -----
// Port-level checks for the seam finder, bound to the top level.
`timescale 1ns / 1ps
module msf_checker
    import msf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [ROW_W-1:0]      o_row,
    input logic [COL_W-1:0]      o_seam_column,
    input logic                  o_last
);

    // A stalled seam entry holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_row) &&
        $stable(o_seam_column) && $stable(o_last))
        else $error("seam entry changed while stalled");

    // More rows pending: input stays closed
    a_busy_mid_seam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("input opened before the seam was complete");

    // Nothing follows the bottom row until a new frame
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> !o_valid)
        else $error("seam entry after the last row");

    // A top-row entry only appears after the input has closed
    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && o_row == '0 |-> $past(!o_ready))
        else $error("top row emitted while loading");

endmodule

bind min_energy_seam_finder_core msf_checker u_msf_checker (.*);

// ----- verif/tb_min_energy_seam_finder_core.sv -----
// Testbench for the minimum-energy vertical seam finder core.
`timescale 1ns / 1ps

module tb_min_energy_seam_finder_core;
    import msf_pkg::*;

    localparam int MAX_W      = 256;
    localparam int MAX_H      = 64;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 40;
    localparam int HOLD_LEN   = 400;
    localparam int ITEM_GOAL  = 330;

    typedef enum int { PIX_FULL, PIX_TIES, PIX_EXTREME } pixel_mix_t;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
    } seam_entry_t;

    // Predicts the seam of each completed frame and checks the output stream
    class seam_scoreboard;
        int unsigned width_reg  = 256;
        int unsigned height_reg = 64;
        int unsigned frame_pix[$];
        int unsigned energy[MAX_H][MAX_W];
        seam_entry_t seam_q[$];
        int errors;
        int frames_done;
        int entries_seen;

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = data;
                frame_pix.delete();
            end else if (idx == REG_IMAGE_HEIGHT) begin
                height_reg = data[CFG_H_W-1:0];
                frame_pix.delete();
            end
        endfunction

        function void note_pixel(logic [GRAD_W-1:0] g);
            int unsigned w;
            int unsigned h;
            int unsigned best;
            int unsigned pos;
            int unsigned mid;
            int unsigned lft;
            int unsigned rgt;
            seam_entry_t ent;
            w = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : width_reg;
            h = (height_reg < 1) ? 1 : (height_reg > MAX_H) ? MAX_H : height_reg;
            if (frame_pix.size() >= w * h)
                frame_pix.delete();
            frame_pix.push_back(g);
            if (frame_pix.size() < w * h)
                return;
            // bottom-up cumulative energy
            for (int c = 0; c < w; c++)
                energy[h-1][c] = frame_pix[(h-1)*w + c];
            for (int r = h - 2; r >= 0; r--) begin
                for (int c = 0; c < w; c++) begin
                    best = energy[r+1][c];
                    if (c > 0 && energy[r+1][c-1] < best)
                        best = energy[r+1][c-1];
                    if (c + 1 < w && energy[r+1][c+1] < best)
                        best = energy[r+1][c+1];
                    energy[r][c] = frame_pix[r*w + c] + best;
                end
            end
            // leftmost minimum of the top row
            pos = 0;
            for (int c = 1; c < w; c++)
                if (energy[0][c] < energy[0][pos])
                    pos = c;
            ent.row = '0;
            ent.column = COL_W'(pos);
            ent.last = (h == 1);
            seam_q.push_back(ent);
            // trace down: right on strict win, then left on strict win
            for (int r = 1; r < h; r++) begin
                mid = energy[r][pos];
                lft = (pos > 0) ? energy[r][pos-1] : 32'hFFFF_FFFF;
                rgt = (pos < w - 1) ? energy[r][pos+1] : 32'hFFFF_FFFF;
                if (rgt < mid && rgt < lft)
                    pos++;
                else if (lft < mid)
                    pos--;
                ent.row = ROW_W'(r);
                ent.column = COL_W'(pos);
                ent.last = (r == h - 1);
                seam_q.push_back(ent);
            end
            frame_pix.delete();
            frames_done++;
        endfunction

        function void check_entry(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic last);
            seam_entry_t exp_ent;
            entries_seen++;
            if (seam_q.size() == 0) begin
                $display("%0t: unexpected seam entry row=%0d col=%0d last=%0d",
                         $time, row, col, last);
                errors++;
                return;
            end
            exp_ent = seam_q.pop_front();
            if (row !== exp_ent.row) begin
                $display("%0t: row mismatch expected %0d actual %0d", $time, exp_ent.row, row);
                errors++;
            end
            if (col !== exp_ent.column) begin
                $display("%0t: seam_column mismatch row %0d expected %0d actual %0d",
                         $time, exp_ent.row, exp_ent.column, col);
                errors++;
            end
            if (last !== exp_ent.last) begin
                $display("%0t: last mismatch row %0d expected %0d actual %0d",
                         $time, exp_ent.row, exp_ent.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [GRAD_W-1:0]     i_gradient;
    logic                  o_valid;
    logic                  i_ready;
    logic [ROW_W-1:0]      o_row;
    logic [COL_W-1:0]      o_seam_column;
    logic                  o_last;

    seam_scoreboard sb = new();
    int  cycle_count;
    int  pixels_sent;
    int  burst_left;
    int  hold_left;
    bit  hold_req;
    bit  clean_mode;

    min_energy_seam_finder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_gradient    (i_gradient),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row         (o_row),
        .o_seam_column (o_seam_column),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side: random stall pattern, clean stretches, and a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                sb.check_entry(o_row, o_seam_column, o_last);
            if (hold_req && hold_left == 0) begin
                hold_left <= HOLD_LEN;
                hold_req  <= 1'b0;
                i_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0)
                    clean_mode <= ~clean_mode;
                i_ready <= clean_mode ? 1'b1 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Register write; only issued while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // One pixel transaction; sender works in bursts with random gaps
    task automatic send_pixel(logic [GRAD_W-1:0] g);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_gradient <= g;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(g);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.seam_q.size() > 0 || hold_left > 0 || hold_req)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [GRAD_W-1:0] pick_pixel(pixel_mix_t mix);
        case (mix)
            PIX_TIES:    return GRAD_W'($urandom_range(0, 3));
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default:     return GRAD_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Configure, then stream whole frames; optionally hold off the output meanwhile
    task automatic run_frames(int wdat, int hdat, int nframes, pixel_mix_t mix,
                              bit hold = 1'b0);
        int w;
        int h;
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wdat));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hdat));
        if (hold)
            hold_req <= 1'b1;
        w = (wdat < 2) ? 2 : (wdat > MAX_W) ? MAX_W : wdat;
        h = ((hdat & 127) < 1) ? 1 : ((hdat & 127) > MAX_H) ? MAX_H : (hdat & 127);
        for (int f = 0; f < nframes; f++)
            for (int p = 0; p < w * h; p++)
                send_pixel(pick_pixel(mix));
    endtask

    initial begin
        int wsel;
        int hsel;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_gradient  = '0;
        i_ready     = 1'b0;
        hold_req    = 1'b0;
        hold_left   = 0;
        clean_mode  = 1'b0;
        cycle_count = 0;
        pixels_sent = 0;
        burst_left  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two-column single-row frames with extreme values and a tie
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 9'd2);
        write_reg(REG_IMAGE_HEIGHT, 9'd1);
        send_pixel(8'd0);   send_pixel(8'd255);
        send_pixel(8'd255); send_pixel(8'd0);
        send_pixel(8'd7);   send_pixel(8'd7);

        // Directed: partial frame discarded by a register write, unknown indexes ignored
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 9'd2);
        send_pixel(8'd1); send_pixel(8'd2); send_pixel(8'd3);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 9'd2);
        write_reg(2'd2, 9'h1FF);
        write_reg(2'd3, 9'h000);
        send_pixel(8'd9); send_pixel(8'd1); send_pixel(8'd4); send_pixel(8'd4);

        // Directed: 3x3 frame where right and left both improve on straight down
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 9'd3);
        write_reg(REG_IMAGE_HEIGHT, 9'd3);
        send_pixel(8'd5); send_pixel(8'd0); send_pixel(8'd5);
        send_pixel(8'd1); send_pixel(8'd9); send_pixel(8'd1);
        send_pixel(8'd0); send_pixel(8'd9); send_pixel(8'd0);

        // Out-of-range registers get clamped: narrowest, shortest, tallest
        run_frames(0, 0, 1, PIX_EXTREME);
        run_frames(1, 127, 1, PIX_FULL);

        // Random small frames; the first ones run under a long output hold-off
        run_frames(4, 3, 3, PIX_TIES, 1'b1);
        while (pixels_sent < ITEM_GOAL) begin
            wsel = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 6);
            hsel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 5);
            run_frames(wsel, hsel, $urandom_range(1, 2), pixel_mix_t'($urandom_range(0, 2)));
        end
        wait_idle();

        $display("Sent %0d pixels in %0d frames, checked %0d seam entries.",
                 pixels_sent, sb.frames_done, sb.entries_seen);
        $display("Covered clamped sizes, single-row frames, discarded partial frames, ties.");
        if (sb.errors == 0 && sb.seam_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
